/* hdl/rgbpf_pkg.sv */
`default_nettype none
package rgbpf_pkg;

	localparam int PADDR_W = 5;
	localparam int REG_IDX_W = 3;

	// Register indexes on the configuration port (byte address = 4 * index).
	localparam logic [REG_IDX_W-1:0] REG_YUV_MODE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INVERT      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MASK_FIRST  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MASK_SECOND = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MASK_THIRD  = 3'd4;

	// Fixed-point color transform, scaled by 8192.
	localparam int SUM_W = 22;
	localparam logic [SUM_W-1:0] Y_R = 22'd2105;
	localparam logic [SUM_W-1:0] Y_G = 22'd4128;
	localparam logic [SUM_W-1:0] Y_B = 22'd802;
	localparam logic [SUM_W-1:0] V_R = 22'd3596;
	localparam logic [SUM_W-1:0] V_G = 22'd3015;
	localparam logic [SUM_W-1:0] V_B = 22'd582;
	localparam logic [SUM_W-1:0] U_R = 22'd1212;
	localparam logic [SUM_W-1:0] U_G = 22'd2384;
	localparam logic [SUM_W-1:0] U_B = 22'd3596;
	localparam logic [SUM_W-1:0] NEG_ROUND = 22'd8191;
	localparam logic [7:0] Y_OFFSET = 8'd16;
	localparam logic [7:0] C_OFFSET = 8'd128;
	localparam logic [7:0] COMP_ONES = 8'd255;

	// floor(m / 255) for 32-bit m equals (m * 0x80808081) >> 39.
	localparam logic [31:0] RECIP_255 = 32'h80808081;
	localparam int RECIP_SHIFT = 39;
	localparam int QUOT_W = 25;
	localparam int SHIFT_W = 6;

	typedef struct packed {
		logic [QUOT_W-1:0]  quot;
		logic [SHIFT_W-1:0] shift;
		logic [31:0]        window;
	} mask_info_t;

	// Truncating division by 8192 of a two's complement sum, plus offset,
	// kept to eight bits.
	function automatic logic [7:0] to_comp(input logic [SUM_W-1:0] sum,
		input logic [7:0] offset);
		logic [SUM_W-1:0] t;
		begin
			t = sum + (sum[SUM_W-1] ? NEG_ROUND : '0);
			to_comp = t[20:13] + offset;
		end
	endfunction

endpackage
`default_nettype wire

/* hdl/rgbpf_mask_decode.sv */
`default_nettype none
module rgbpf_mask_decode (
	input  wire logic                clk,
	input  wire logic [31:0]         mask,
	output rgbpf_pkg::mask_info_t    info
);

	logic [63:0] prod;
	logic [4:0] low_idx;
	logic [5:0] ones;

	always_comb begin
		prod = {32'd0, mask} * {32'd0, rgbpf_pkg::RECIP_255};
		ones = '0;
		for (int i = 0; i < 32; i++) begin
			ones = ones + {5'd0, mask[i]};
		end
		// Lowest set bit; a zero mask gives position zero.
		low_idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (mask[i]) begin
				low_idx = 5'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		info.quot   <= prod[rgbpf_pkg::RECIP_SHIFT +: rgbpf_pkg::QUOT_W];
		info.shift  <= {1'b0, low_idx} + ones;
		info.window <= {mask[23:0], 8'd0};
	end

endmodule
`default_nettype wire

/* hdl/rgb_to_pixel_format_unit.sv */
`default_nettype none
// Four-stage pipeline: each result passes the registers of stages 1 to 4 in turn.
// One pixel per cycle while m_axis_tready holds; a stage moves when the next is free.
// Mask decode (quotient by 255, shift, window) is registered from the mask registers.
// arst_n clears all valid bits and the configuration registers to zero.
module rgb_to_pixel_format_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // packed_pixel [31:0]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [rgbpf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic yuv_mode_q, invert_q;
	logic [31:0] mask0_q, mask1_q, mask2_q;
	logic [rgbpf_pkg::REG_IDX_W-1:0] reg_idx;
	logic wr_en;

	rgbpf_pkg::mask_info_t info0, info1, info2;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;

	logic [rgbpf_pkg::SUM_W-1:0] y_sum, u_sum, v_sum, r_w, g_w, b_w;
	logic [rgbpf_pkg::SUM_W-1:0] y_sum_s1, u_sum_s1, v_sum_s1;
	logic [23:0] rgb_s1;
	logic [7:0] c0, c1, c2;
	logic [7:0] c0_s2, c1_s2, c2_s2;
	logic [39:0] sh0, sh1, sh2;
	logic [32:0] p0, p1, p2;
	logic [31:0] t0, t1, t2;
	logic [31:0] t0_s3, t1_s3, t2_s3;
	logic [31:0] word, word_s4;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[rgbpf_pkg::PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yuv_mode_q <= 1'b0;
			invert_q   <= 1'b0;
			mask0_q    <= '0;
			mask1_q    <= '0;
			mask2_q    <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				rgbpf_pkg::REG_YUV_MODE:    yuv_mode_q <= pwdata[0];
				rgbpf_pkg::REG_INVERT:      invert_q   <= pwdata[0];
				rgbpf_pkg::REG_MASK_FIRST:  mask0_q    <= pwdata;
				rgbpf_pkg::REG_MASK_SECOND: mask1_q    <= pwdata;
				rgbpf_pkg::REG_MASK_THIRD:  mask2_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rgbpf_pkg::REG_YUV_MODE:    prdata = {31'd0, yuv_mode_q};
			rgbpf_pkg::REG_INVERT:      prdata = {31'd0, invert_q};
			rgbpf_pkg::REG_MASK_FIRST:  prdata = mask0_q;
			rgbpf_pkg::REG_MASK_SECOND: prdata = mask1_q;
			rgbpf_pkg::REG_MASK_THIRD:  prdata = mask2_q;
			default:                    prdata = '0;
		endcase
	end

	rgbpf_mask_decode u_dec0 (.clk(clk), .mask(mask0_q), .info(info0));
	rgbpf_mask_decode u_dec1 (.clk(clk), .mask(mask1_q), .info(info1));
	rgbpf_mask_decode u_dec2 (.clk(clk), .mask(mask2_q), .info(info2));

	// Each stage advances when it is empty or the stage after it advances.
	assign en4 = !v4_s4 || m_axis_tready;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v1_s1 <= s_axis_tvalid;
			end
			if (en2) begin
				v2_s2 <= v1_s1;
			end
			if (en3) begin
				v3_s3 <= v2_s2;
			end
			if (en4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	// Stage 1: weighted sums, modulo 2^22 as two's complement.
	always_comb begin
		r_w = {14'd0, s_axis_tdata[7:0]};
		g_w = {14'd0, s_axis_tdata[15:8]};
		b_w = {14'd0, s_axis_tdata[23:16]};
		y_sum = r_w * rgbpf_pkg::Y_R + g_w * rgbpf_pkg::Y_G + b_w * rgbpf_pkg::Y_B;
		v_sum = r_w * rgbpf_pkg::V_R - g_w * rgbpf_pkg::V_G - b_w * rgbpf_pkg::V_B;
		u_sum = b_w * rgbpf_pkg::U_B - r_w * rgbpf_pkg::U_R - g_w * rgbpf_pkg::U_G;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			y_sum_s1 <= y_sum;
			u_sum_s1 <= u_sum;
			v_sum_s1 <= v_sum;
			rgb_s1   <= s_axis_tdata;
		end
	end

	// Stage 2: in YUV mode scale down to 8-bit components; apply the invert option.
	always_comb begin
		if (yuv_mode_q) begin
			c0 = rgbpf_pkg::to_comp(y_sum_s1, rgbpf_pkg::Y_OFFSET);
			c1 = rgbpf_pkg::to_comp(u_sum_s1, rgbpf_pkg::C_OFFSET);
			c2 = rgbpf_pkg::to_comp(v_sum_s1, rgbpf_pkg::C_OFFSET);
		end else begin
			c0 = rgb_s1[7:0];
			c1 = rgb_s1[15:8];
			c2 = rgb_s1[23:16];
		end
		if (invert_q) begin
			c0 = c0 ^ rgbpf_pkg::COMP_ONES;
			c1 = c1 ^ rgbpf_pkg::COMP_ONES;
			c2 = c2 ^ rgbpf_pkg::COMP_ONES;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			c0_s2 <= c0;
			c1_s2 <= c1;
			c2_s2 <= c2;
		end
	end

	// Stage 3: scale by mask quotient, or place each channel inside its mask.
	always_comb begin
		p0 = {8'd0, info0.quot} * {25'd0, c0_s2};
		p1 = {8'd0, info1.quot} * {25'd0, c1_s2};
		p2 = {8'd0, info2.quot} * {25'd0, c2_s2};
		sh0 = {32'd0, c0_s2} << info0.shift;
		sh1 = {32'd0, c1_s2} << info1.shift;
		sh2 = {32'd0, c2_s2} << info2.shift;
		if (yuv_mode_q) begin
			t0 = p0[31:0];
			t1 = p1[31:0];
			t2 = p2[31:0];
		end else begin
			t0 = sh0[31:0] & info0.window;
			t1 = sh1[31:0] & info1.window;
			t2 = sh2[31:0] & info2.window;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			t0_s3 <= t0;
			t1_s3 <= t1;
			t2_s3 <= t2;
		end
	end

	// Stage 4: merge the three terms.
	always_comb begin
		if (yuv_mode_q) begin
			word = t0_s3 + t1_s3 + t2_s3;
		end else begin
			word = (t0_s3 | t1_s3 | t2_s3) >> 8;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			word_s4 <= word;
		end
	end

	assign m_axis_tvalid = v4_s4;
	assign m_axis_tdata  = word_s4;

`ifndef NO_ASSERTIONS
	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> s_axis_tready)
		else $error("input not ready although the first stage is empty");

	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v3_s3))
		else $error("result appeared without an item in the third stage");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 |-> (info0.shift <= 6'd32 && info1.shift <= 6'd32 && info2.shift <= 6'd32))
		else $error("mask shift amount beyond 32");
`endif

endmodule
`default_nettype wire
